### hw/rtl/uxb_pkg.sv
`default_nettype none

package uxb_pkg;

    // Line control and line-ending characters.
    localparam logic [7:0] XOFF_CHAR = 8'h13;
    localparam logic [7:0] XON_CHAR  = 8'h11;
    localparam logic [7:0] CR_CHAR   = 8'h0D;
    localparam logic [7:0] LF_CHAR   = 8'h0A;

    // Reset value of the af_level configuration register.
    localparam logic [6:0] LEVEL_RESET = 7'd56;

    // Event kinds carried in the low bits of the input tuser.
    typedef enum logic [1:0] {
        OP_LINE_RX = 2'd0,
        OP_TX_SLOT = 2'd1,
        OP_HOST_WR = 2'd2,
        OP_HOST_RD = 2'd3
    } t_op;

    // Status codes reported with each result.
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_RX_DROPPED = 3'd1,
        STAT_TX_FULL    = 3'd2,
        STAT_RX_EMPTY   = 3'd3,
        STAT_LF_DROPPED = 3'd4,
        STAT_ECHO_DROP  = 3'd5
    } t_status;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FLOW_CTRL = 3'd0,
        CFG_LINE_FIX  = 3'd1,
        CFG_ECHO      = 3'd2,
        CFG_RAW_READS = 3'd3,
        CFG_AF_LEVEL  = 3'd4
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic       flow_on;
        logic       line_fix;
        logic       echo_on;
        logic       raw_reads;
        logic [6:0] af_level;
    } t_cfg;

    // Push/pop request to one FIFO for the current item.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } t_fifo_req;

    // Flags that one FIFO reports to the event logic.
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] rd_data;
    } t_fifo_stat;

    // Decision of the event logic for one item.
    typedef struct packed {
        t_fifo_req  rx_req;
        t_fifo_req  tx_req;
        logic       stop_set;
        logic       stop_clr;
        logic       xoff_chk;
        logic       xoff_clr;
        logic       prev_we;
        logic [7:0] prev_data;
        logic       line_valid;
        logic [7:0] line_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        t_status    status;
    } t_step;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic       xoff_waiting;
        logic       peer_stopped;
        logic [6:0] tx_fill;
        logic [6:0] rx_fill;
        t_status    status;
        logic [7:0] read_byte;
        logic       read_valid;
        logic [7:0] line_byte;
        logic       line_valid;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/uxb_fifo.sv
`default_nettype none

module uxb_fifo #(
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire uxb_pkg::t_fifo_req         i_req,
    output      uxb_pkg::t_fifo_stat        o_stat,
    output      logic [$clog2(DEPTH+1)-1:0] o_count_next
);
    import uxb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;

    // Storage: one write port at the tail, one registered read of the head.
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_tail] <= i_req.wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // Pointer and fill count updates with wrap at the depth.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_req.pop) begin
            n_head = (r_head == LAST) ? '0 : r_head + AW'(1);
        end
        if (i_req.push) begin
            n_tail = (r_tail == LAST) ? '0 : r_tail + AW'(1);
        end
        n_count = r_count + CW'(i_req.push) - CW'(i_req.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_stat.empty   = (r_count == '0);
    assign o_stat.full    = (r_count == FULL);
    assign o_stat.rd_data = r_rd_data;
    assign o_count_next   = n_count;

endmodule

`default_nettype wire

### hw/rtl/uxb_step.sv
`default_nettype none

module uxb_step (
    input  wire uxb_pkg::t_op        i_op,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_may_wait,
    input  wire uxb_pkg::t_cfg       i_cfg,
    input  wire uxb_pkg::t_fifo_stat i_rx,
    input  wire uxb_pkg::t_fifo_stat i_tx,
    input  wire logic                i_xoff_pending,
    input  wire logic                i_stopped,
    input  wire logic [7:0]          i_prev_read,
    output      uxb_pkg::t_step      o_step
);
    import uxb_pkg::*;

    logic [7:0] ch;
    logic       lf_drop;

    // Line-ending fix on a cooked read of the head byte.
    always_comb begin
        ch      = i_rx.rd_data;
        lf_drop = 1'b0;
        if (i_cfg.line_fix) begin
            if (i_rx.rd_data == LF_CHAR && i_prev_read == CR_CHAR) begin
                lf_drop = 1'b1;
            end else if (i_rx.rd_data == CR_CHAR) begin
                ch = LF_CHAR;
            end
        end
    end

    // Decide pushes, pops, flag changes and the reported result.
    always_comb begin
        o_step = '0;
        o_step.status = STAT_OK;
        o_step.rx_req.wdata = i_data_byte;
        o_step.tx_req.wdata = i_data_byte;
        unique case (i_op)
            OP_LINE_RX: begin
                if (i_cfg.flow_on && i_data_byte == XOFF_CHAR) begin
                    o_step.stop_set = 1'b1;
                end else if (i_cfg.flow_on && i_data_byte == XON_CHAR) begin
                    o_step.stop_clr = 1'b1;
                end else begin
                    o_step.xoff_chk = 1'b1;
                    if (!i_rx.full) begin
                        o_step.rx_req.push = 1'b1;
                    end else begin
                        o_step.status = STAT_RX_DROPPED;
                    end
                end
            end
            OP_TX_SLOT: begin
                if (!i_tx.empty) begin
                    if (!i_cfg.flow_on || (!i_xoff_pending && !i_stopped)) begin
                        o_step.line_valid  = 1'b1;
                        o_step.line_byte   = i_tx.rd_data;
                        o_step.tx_req.pop  = 1'b1;
                    end else if (i_xoff_pending) begin
                        o_step.line_valid = 1'b1;
                        o_step.line_byte  = XOFF_CHAR;
                        o_step.xoff_clr   = 1'b1;
                    end
                end
            end
            OP_HOST_WR: begin
                if (!i_tx.full) begin
                    o_step.tx_req.push = 1'b1;
                end else begin
                    o_step.status = STAT_TX_FULL;
                end
            end
            OP_HOST_RD: begin
                if (i_rx.empty) begin
                    o_step.status = STAT_RX_EMPTY;
                end else if (i_cfg.raw_reads || !i_may_wait) begin
                    o_step.rx_req.pop = 1'b1;
                    o_step.read_valid = 1'b1;
                    o_step.read_byte  = i_rx.rd_data;
                end else begin
                    o_step.rx_req.pop = 1'b1;
                    o_step.prev_we    = i_cfg.line_fix && !lf_drop;
                    o_step.prev_data  = i_rx.rd_data;
                    if (lf_drop) begin
                        o_step.status = STAT_LF_DROPPED;
                    end else begin
                        o_step.read_valid = 1'b1;
                        o_step.read_byte  = ch;
                        o_step.tx_req.wdata = ch;
                        if (i_cfg.echo_on) begin
                            if (!i_tx.full) begin
                                o_step.tx_req.push = 1'b1;
                            end else begin
                                o_step.status = STAT_ECHO_DROP;
                            end
                        end
                    end
                end
            end
            default: begin
                o_step.status = STAT_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/uart_xon_xoff_byte_buffer.sv
// UART byte buffer with XON/XOFF flow control. Each input beat is one event
// (line byte received, transmit slot, host write or host read) and yields
// exactly one result beat. An item has two steps: first the head entries
// of the receive and transmit FIFO memories are read (registered synchronous
// read), then the event is decided and the memories, pointers and flags are
// written back. The next item is taken only once the last is written back;
// a waiting result stalls the input only when the next result would need
// its register. The memories need no clear after reset: only entries that
// were written are ever used.
`default_nettype none

module uart_xon_xoff_byte_buffer #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [6:0]  i_cfg_data,
    // Event stream.
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic [2:0]  s_axis_tuser,  // [1:0] op, [2] may_wait
    // Result stream.
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
    // [20:18] status, [27:21] rx_fill, [34:28] tx_fill, [35] peer_stopped,
    // [36] xoff_waiting, [39:37] zero
    output      logic [39:0] m_axis_tdata
);
    import uxb_pkg::*;

    localparam int RCW = $clog2(RX_DEPTH + 1);
    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam int LW  = (RCW > 7) ? RCW : 7;

    t_state     r_state;
    t_state     n_state;
    t_cfg       r_cfg;
    t_op        r_op;
    logic [7:0] r_data_byte;
    logic       r_may_wait;
    logic       r_xoff;
    logic       r_stopped;
    logic [7:0] r_prev;
    logic       r_out_valid;
    t_result    r_out;

    logic       accept;
    logic       exec;
    t_step      step;
    t_fifo_req  rx_req;
    t_fifo_req  tx_req;
    t_fifo_stat rx_stat;
    t_fifo_stat tx_stat;
    logic [RCW-1:0] rx_count_next;
    logic [TCW-1:0] tx_count_next;
    logic       at_level;
    logic       n_xoff;
    logic       n_stopped;
    t_result    result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flow_on   <= 1'b1;
            r_cfg.line_fix  <= 1'b1;
            r_cfg.echo_on   <= 1'b0;
            r_cfg.raw_reads <= 1'b0;
            r_cfg.af_level  <= LEVEL_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FLOW_CTRL: r_cfg.flow_on   <= i_cfg_data[0];
                CFG_LINE_FIX:  r_cfg.line_fix  <= i_cfg_data[0];
                CFG_ECHO:      r_cfg.echo_on   <= i_cfg_data[0];
                CFG_RAW_READS: r_cfg.raw_reads <= i_cfg_data[0];
                CFG_AF_LEVEL:  r_cfg.af_level  <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        exec          = 1'b0;
        unique case (r_state)
            S_IDLE:  s_axis_tready = !r_out_valid || m_axis_tready;
            S_EXEC:  exec = 1'b1;
            default: exec = 1'b0;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the event beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= t_op'(s_axis_tuser[1:0]);
            r_may_wait  <= s_axis_tuser[2];
            r_data_byte <= s_axis_tdata;
        end
    end

    // FIFO memories; the head read is issued as the beat is accepted.
    uxb_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (accept),
        .i_req        (rx_req),
        .o_stat       (rx_stat),
        .o_count_next (rx_count_next)
    );

    uxb_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (accept),
        .i_req        (tx_req),
        .o_stat       (tx_stat),
        .o_count_next (tx_count_next)
    );

    uxb_step u_step (
        .i_op           (r_op),
        .i_data_byte    (r_data_byte),
        .i_may_wait     (r_may_wait),
        .i_cfg          (r_cfg),
        .i_rx           (rx_stat),
        .i_tx           (tx_stat),
        .i_xoff_pending (r_xoff),
        .i_stopped      (r_stopped),
        .i_prev_read    (r_prev),
        .o_step         (step)
    );

    // FIFO requests only take effect in the execute cycle.
    always_comb begin
        rx_req      = step.rx_req;
        tx_req      = step.tx_req;
        rx_req.push = step.rx_req.push && exec;
        rx_req.pop  = step.rx_req.pop && exec;
        tx_req.push = step.tx_req.push && exec;
        tx_req.pop  = step.tx_req.pop && exec;
    end

    // Flow-control flags after the item.
    always_comb begin
        at_level  = LW'(rx_count_next) >= LW'(r_cfg.af_level);
        n_xoff    = r_xoff;
        n_stopped = r_stopped;
        if (step.xoff_chk && at_level) begin
            n_xoff = 1'b1;
        end else if (step.xoff_clr) begin
            n_xoff = 1'b0;
        end
        if (step.stop_set) begin
            n_stopped = 1'b1;
        end else if (step.stop_clr) begin
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xoff    <= 1'b0;
            r_stopped <= 1'b0;
            r_prev    <= '0;
        end else if (exec) begin
            r_xoff    <= n_xoff;
            r_stopped <= n_stopped;
            if (step.prev_we) begin
                r_prev <= step.prev_data;
            end
        end
    end

    // Assemble the result beat; fill counts are reported in seven bits.
    always_comb begin
        result.line_valid   = step.line_valid;
        result.line_byte    = step.line_byte;
        result.read_valid   = step.read_valid;
        result.read_byte    = step.read_byte;
        result.status       = step.status;
        result.rx_fill      = 7'(rx_count_next);
        result.tx_fill      = 7'(tx_count_next);
        result.peer_stopped = n_stopped;
        result.xoff_waiting = n_xoff;
    end

    // Output register; it is always free by the execute cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    // An accepted beat is executed in the very next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

    // Every execute cycle leaves a result waiting.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_out_valid)
        else $error("execute cycle gave no result");

    // The execute cycle never overwrites a result that was not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |-> (!r_out_valid || $past(m_axis_tready)))
        else $error("result overwritten");

    // One item never pushes and pops the same FIFO.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tx_req.push && tx_req.pop) && !(rx_req.push && rx_req.pop))
        else $error("push and pop in one item");

endmodule

`default_nettype wire

### tb/tb_uart_xon_xoff_byte_buffer.sv
`default_nettype none

module tb_uart_xon_xoff_byte_buffer;

    import uxb_pkg::*;

    localparam int FIFO_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 105;

    // Stimulus modes: op mixes, plus pure receive and pure host-write bursts.
    localparam int MIX_BALANCED = 0;
    localparam int MIX_RX_FILL = 1;
    localparam int MIX_DRAIN = 2;
    localparam int MIX_TX_FILL = 3;
    localparam int BURST_RX = 4;
    localparam int BURST_WR = 5;

    // Idle profiles of the two stream sides.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct {
        t_op        op;
        logic [7:0] data;
        logic       may_wait;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic [2:0]  s_axis_tuser = '0;   // [1:0] op, [2] may_wait
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
    // [20:18] status, [27:21] rx_fill, [34:28] tx_fill, [35] peer_stopped,
    // [36] xoff_waiting, [39:37] zero
    logic [39:0] m_axis_tdata;

    uart_xon_xoff_byte_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Event stream waiting to be sent and results waiting to be seen.
    t_event  event_queue[$];
    t_result awaited_results[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // Predicted configuration.
    logic       cfg_flow;
    logic       cfg_fix;
    logic       cfg_echo;
    logic       cfg_raw;
    logic [6:0] cfg_level;

    // Predicted buffer state.
    logic [7:0] rx_mem[FIFO_DEPTH];
    logic [5:0] rx_rd;
    logic [6:0] rx_cnt;
    logic [7:0] tx_mem[FIFO_DEPTH];
    logic [5:0] tx_rd;
    logic [6:0] tx_cnt;
    logic       xoff_due;
    logic       peer_held;
    logic [7:0] last_read;

    function automatic logic [7:0] rx_take();
        logic [7:0] b;
        b = rx_mem[rx_rd];
        rx_rd++;
        rx_cnt--;
        return b;
    endfunction

    function automatic logic [7:0] tx_take();
        logic [7:0] b;
        b = tx_mem[tx_rd];
        tx_rd++;
        tx_cnt--;
        return b;
    endfunction

    function automatic void tx_put(logic [7:0] b);
        tx_mem[tx_rd + tx_cnt[5:0]] = b;
        tx_cnt++;
    endfunction

    // Applies one event to the predicted state and returns its result beat.
    function automatic t_result compute_buffer_step(t_op op, logic [7:0] b, logic mw);
        t_result r;
        logic [7:0] ch;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_LINE_RX: begin
                if (cfg_flow && b == XOFF_CHAR) begin
                    peer_held = 1'b1;
                end else if (cfg_flow && b == XON_CHAR) begin
                    peer_held = 1'b0;
                end else begin
                    if (rx_cnt < FIFO_DEPTH) begin
                        rx_mem[rx_rd + rx_cnt[5:0]] = b;
                        rx_cnt++;
                    end else begin
                        r.status = STAT_RX_DROPPED;
                    end
                    if (rx_cnt >= cfg_level) xoff_due = 1'b1;
                end
            end
            OP_TX_SLOT: begin
                if (tx_cnt != 0) begin
                    if (!cfg_flow) begin
                        r.line_valid = 1'b1;
                        r.line_byte = tx_take();
                    end else if (xoff_due) begin
                        r.line_valid = 1'b1;
                        r.line_byte = XOFF_CHAR;
                        xoff_due = 1'b0;
                    end else if (!peer_held) begin
                        r.line_valid = 1'b1;
                        r.line_byte = tx_take();
                    end
                end
            end
            OP_HOST_WR: begin
                if (tx_cnt < FIFO_DEPTH) tx_put(b);
                else r.status = STAT_TX_FULL;
            end
            default: begin
                if (rx_cnt == 0) begin
                    r.status = STAT_RX_EMPTY;
                end else if (cfg_raw || !mw) begin
                    r.read_valid = 1'b1;
                    r.read_byte = rx_take();
                end else begin
                    ch = rx_take();
                    if (cfg_fix && ch == LF_CHAR && last_read == CR_CHAR) begin
                        // The LF of a CR LF pair is swallowed.
                        r.status = STAT_LF_DROPPED;
                    end else begin
                        if (cfg_fix) begin
                            last_read = ch;
                            if (ch == CR_CHAR) ch = LF_CHAR;
                        end
                        r.read_valid = 1'b1;
                        r.read_byte = ch;
                        if (cfg_echo) begin
                            if (tx_cnt < FIFO_DEPTH) tx_put(ch);
                            else r.status = STAT_ECHO_DROP;
                        end
                    end
                end
            end
        endcase
        r.rx_fill = rx_cnt;
        r.tx_fill = tx_cnt;
        r.peer_stopped = peer_held;
        r.xoff_waiting = xoff_due;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Driver: presents queued events and predicts each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(compute_buffer_step(t_op'(s_axis_tuser[1:0]),
                                                              s_axis_tdata, s_axis_tuser[2]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (event_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= event_queue[0].data;
                    s_axis_tuser <= {event_queue[0].may_wait, event_queue[0].op};
                    void'(event_queue.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison.
    t_result got_beat;
    t_result want_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result beat with no event waiting for it");
                end else begin
                    got_beat = t_result'(m_axis_tdata[36:0]);
                    want_beat = awaited_results.pop_front();
                    check_field("line_valid", got_beat.line_valid, want_beat.line_valid);
                    check_field("line_byte", got_beat.line_byte, want_beat.line_byte);
                    check_field("read_valid", got_beat.read_valid, want_beat.read_valid);
                    check_field("read_byte", got_beat.read_byte, want_beat.read_byte);
                    check_field("status", got_beat.status, want_beat.status);
                    check_field("rx_fill", got_beat.rx_fill, want_beat.rx_fill);
                    check_field("tx_fill", got_beat.tx_fill, want_beat.tx_fill);
                    check_field("peer_stopped", got_beat.peer_stopped, want_beat.peer_stopped);
                    check_field("xoff_waiting", got_beat.xoff_waiting, want_beat.xoff_waiting);
                    check_field("padding", m_axis_tdata[39:37], 0);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("uart_xon_xoff_byte_buffer regression: fail");
            $finish;
        end
    end

    task automatic push_event(t_op op, logic [7:0] data, logic mw);
        t_event e;
        e.op = op;
        e.data = data;
        e.may_wait = mw;
        event_queue.push_back(e);
    endtask

    // Waits until every queued event has been sent and every result seen.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (event_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [6:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_FLOW_CTRL: cfg_flow = value[0];
            CFG_LINE_FIX:  cfg_fix = value[0];
            CFG_ECHO:      cfg_echo = value[0];
            CFG_RAW_READS: cfg_raw = value[0];
            CFG_AF_LEVEL:  cfg_level = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic flow, logic fix, logic echo, logic raw, logic [6:0] level);
        write_reg(CFG_FLOW_CTRL, {6'h3F, flow});
        write_reg(CFG_LINE_FIX, {6'h00, fix});
        write_reg(CFG_ECHO, {6'h2A, echo});
        write_reg(CFG_RAW_READS, {6'h15, raw});
        write_reg(CFG_AF_LEVEL, level);
    endtask

    // Bytes lean toward the control and line-ending characters.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return XOFF_CHAR;
            1: return XON_CHAR;
            2: return CR_CHAR;
            3: return LF_CHAR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_op pick_op(int mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MIX_RX_FILL: return (r < 50) ? OP_LINE_RX : (r < 65) ? OP_TX_SLOT :
                                (r < 90) ? OP_HOST_WR : OP_HOST_RD;
            MIX_DRAIN:   return (r < 10) ? OP_LINE_RX : (r < 50) ? OP_TX_SLOT :
                                (r < 60) ? OP_HOST_WR : OP_HOST_RD;
            MIX_TX_FILL: return (r < 20) ? OP_LINE_RX : (r < 30) ? OP_TX_SLOT :
                                (r < 80) ? OP_HOST_WR : OP_HOST_RD;
            default:     return (r < 30) ? OP_LINE_RX : (r < 55) ? OP_TX_SLOT :
                                (r < 75) ? OP_HOST_WR : OP_HOST_RD;
        endcase
    endfunction

    task automatic add_random_events(int mode, int count);
        logic [7:0] b;
        t_op op;
        for (int k = 0; k < count; k++) begin
            if (mode == BURST_RX) begin
                // Plain data only, so the receive FIFO really fills.
                b = 8'($urandom_range(255));
                if (b == XOFF_CHAR || b == XON_CHAR) b ^= 8'h40;
                push_event(OP_LINE_RX, b, 1'($urandom_range(1)));
            end else if (mode == BURST_WR) begin
                push_event(OP_HOST_WR, pick_byte(), 1'($urandom_range(1)));
            end else begin
                op = pick_op(mode);
                if (op == OP_LINE_RX && $urandom_range(99) < 15) begin
                    push_event(OP_LINE_RX, CR_CHAR, 1'($urandom_range(1)));
                    push_event(OP_LINE_RX, LF_CHAR, 1'($urandom_range(1)));
                end else if (op == OP_HOST_RD) begin
                    push_event(op, 8'($urandom_range(255)), ($urandom_range(99) < 70));
                end else begin
                    push_event(op, pick_byte(), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    task automatic run_phase(logic flow, logic fix, logic echo, logic raw, logic [6:0] level,
                             int mode, int idle);
        wait_drained();
        sender_idle_pct = (idle == IDLE_SENDER) ? 82 : (idle == IDLE_BOTH) ? 10 : 0;
        receiver_stall_pct = (idle == IDLE_RECEIVER) ? 82 : (idle == IDLE_BOTH) ? 10 : 0;
        set_config(flow, fix, echo, raw, level);
        add_random_events(mode, PHASE_ITEMS);
    endtask

    initial begin
        cfg_flow = 1'b1;
        cfg_fix = 1'b1;
        cfg_echo = 1'b0;
        cfg_raw = 1'b0;
        cfg_level = LEVEL_RESET;
        rx_rd = '0;
        rx_cnt = '0;
        tx_rd = '0;
        tx_cnt = '0;
        xoff_due = 1'b0;
        peer_held = 1'b0;
        last_read = 8'h00;
        foreach (rx_mem[k]) rx_mem[k] = 8'h00;
        foreach (tx_mem[k]) tx_mem[k] = 8'h00;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty reads and slot, stop and resume, CR LF handling.
        push_event(OP_HOST_RD, 8'h00, 1'b1);
        push_event(OP_HOST_RD, 8'hFF, 1'b0);
        push_event(OP_TX_SLOT, 8'h00, 1'b0);
        push_event(OP_HOST_WR, 8'h00, 1'b0);
        push_event(OP_HOST_WR, 8'hFF, 1'b1);
        push_event(OP_LINE_RX, XOFF_CHAR, 1'b0);
        push_event(OP_TX_SLOT, 8'h00, 1'b0);
        push_event(OP_LINE_RX, XON_CHAR, 1'b0);
        push_event(OP_TX_SLOT, 8'h00, 1'b0);
        push_event(OP_LINE_RX, CR_CHAR, 1'b0);
        push_event(OP_LINE_RX, LF_CHAR, 1'b0);
        push_event(OP_LINE_RX, 8'h41, 1'b0);
        push_event(OP_LINE_RX, 8'hFF, 1'b1);
        push_event(OP_HOST_RD, 8'h00, 1'b1);
        push_event(OP_HOST_RD, 8'h00, 1'b1);
        push_event(OP_HOST_RD, 8'h00, 1'b1);
        push_event(OP_HOST_RD, 8'h00, 1'b0);

        // Writes to unused indexes must change nothing; then echo on, level zero.
        wait_drained();
        for (int k = CFG_AF_LEVEL + 1; k < 8; k++) write_reg(3'(k), 7'h7F);
        write_reg(CFG_ECHO, 7'h01);
        write_reg(CFG_AF_LEVEL, 7'h00);
        push_event(OP_LINE_RX, 8'h42, 1'b0);
        push_event(OP_TX_SLOT, 8'h00, 1'b0);
        push_event(OP_HOST_RD, 8'h00, 1'b1);
        push_event(OP_TX_SLOT, 8'h00, 1'b0);
        push_event(OP_TX_SLOT, 8'h00, 1'b0);
        push_event(OP_TX_SLOT, 8'h00, 1'b0);

        // Random phases across settings, FIFO extremes and idle profiles.
        run_phase(1'b1, 1'b1, 1'b0, 1'b0, LEVEL_RESET, MIX_BALANCED, IDLE_NONE);
        run_phase(1'b1, 1'b1, 1'b1, 1'b0, 7'd1, BURST_RX, IDLE_SENDER);
        run_phase(1'b1, 1'b1, 1'b1, 1'b0, 7'd64, BURST_WR, IDLE_RECEIVER);
        run_phase(1'b1, 1'b1, 1'b1, 1'b0, 7'd64, MIX_DRAIN, IDLE_BOTH);
        run_phase(1'b0, 1'b1, 1'b1, 1'b0, 7'd64, MIX_BALANCED, IDLE_NONE);
        run_phase(1'b1, 1'b0, 1'b0, 1'b1, 7'd0, MIX_RX_FILL, IDLE_SENDER);
        run_phase(1'b0, 1'b0, 1'b0, 1'b0, 7'd127, MIX_TX_FILL, IDLE_RECEIVER);
        run_phase(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 7'($urandom_range(64, 1)), MIX_DRAIN, IDLE_BOTH);
        run_phase(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 7'($urandom_range(64, 1)), MIX_RX_FILL, IDLE_NONE);
        run_phase(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 7'($urandom_range(64, 1)), MIX_BALANCED, IDLE_SENDER);
        run_phase(1'b1, 1'b1, 1'b0, 1'b0, LEVEL_RESET, MIX_DRAIN, IDLE_RECEIVER);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("uart_xon_xoff_byte_buffer regression: pass");
        else
            $display("uart_xon_xoff_byte_buffer regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
